FILE: hw/rtl/dcpt_pkg.sv
`default_nettype none
package dcpt_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned CDUTY_W   = 7;
  localparam int unsigned REM_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0]  PERIOD_RST   = 32'd1000;
  localparam logic [DUTY_W-1:0]  DUTY_RST     = 8'd50;
  localparam logic [TIME_W-1:0]  ON_LEN_RST   = 32'd500;
  localparam logic [TIME_W-1:0]  OFF_LEN_RST  = 32'd500;
  localparam logic [DUTY_W-1:0]  DUTY_MIN     = 8'd10;
  localparam logic [DUTY_W-1:0]  DUTY_MAX     = 8'd90;
  localparam logic [REM_W:0]     PCT_DIVISOR  = 8'd100;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } dcpt_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_DUTY   = 2'd1
  } dcpt_reg_t;

  typedef struct packed {
    logic running;
    logic phase_on;
    logic tick_fired;
  } dcpt_result_t;

  function automatic logic [CDUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
    logic [DUTY_W-1:0] c;
    c = d;
    if (d < DUTY_MIN) c = DUTY_MIN;
    if (d > DUTY_MAX) c = DUTY_MAX;
    return c[CDUTY_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dcpt_len_unit.sv
`default_nettype none
module dcpt_len_unit
  import dcpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] period,
  input  wire logic [CDUTY_W-1:0] duty,
  output logic                   busy,
  output logic [TIME_W-1:0]      on_len,
  output logic [TIME_W-1:0]      off_len
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PART = 5'b00100,
    ST_FRAC = 5'b01000,
    ST_SUM  = 5'b10000
  } len_state_t;

  localparam int unsigned MUL_W      = 2 * TIME_W;
  localparam int unsigned QUO_W      = 26;
  localparam int unsigned RECIP_SH   = 37;
  localparam int unsigned FRAC_W     = 14;
  localparam int unsigned FRAC_RW    = 13;
  localparam int unsigned FRAC_PW    = FRAC_W + FRAC_RW;
  localparam int unsigned FRAC_SH    = 19;
  localparam logic [TIME_W-1:0]  RECIP_100  = 32'h51EB_851F;
  localparam logic [FRAC_RW-1:0] FRAC_RECIP = 13'd5243;
  localparam logic [REM_W-1:0]   DIV_LO     = PCT_DIVISOR[REM_W-1:0];

  len_state_t         state_r, state_nxt;
  logic [TIME_W-1:0]  period_r, period_nxt;
  logic [CDUTY_W-1:0] duty_r, duty_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [TIME_W-1:0]  whole_r, whole_nxt;
  logic [FRAC_W-1:0]  part_r, part_nxt;
  logic [REM_W-1:0]   frac_r, frac_nxt;
  logic [TIME_W-1:0]  on_len_r, on_len_nxt;
  logic [TIME_W-1:0]  off_len_r, off_len_nxt;
  logic [MUL_W-1:0]   quo_prod;
  logic [REM_W-1:0]   rem;
  logic [FRAC_PW-1:0] frac_prod;
  logic [TIME_W-1:0]  on_sum;

  // period*d/100 = q*d + (r*d)/100 with q, r = period / 100, period % 100
  assign quo_prod  = MUL_W'(period_r) * MUL_W'(RECIP_100);
  assign rem       = period_r[REM_W-1:0] - quo_r[REM_W-1:0] * DIV_LO;
  assign frac_prod = FRAC_PW'(part_r) * FRAC_PW'(FRAC_RECIP);
  assign on_sum    = whole_r + TIME_W'(frac_r);

  always_comb begin
    state_nxt   = state_r;
    period_nxt  = period_r;
    duty_nxt    = duty_r;
    quo_nxt     = quo_r;
    whole_nxt   = whole_r;
    part_nxt    = part_r;
    frac_nxt    = frac_r;
    on_len_nxt  = on_len_r;
    off_len_nxt = off_len_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_MUL;
          period_nxt = period;
          duty_nxt   = duty;
        end
      end
      ST_MUL: begin
        quo_nxt   = quo_prod[RECIP_SH +: QUO_W];
        state_nxt = ST_PART;
      end
      ST_PART: begin
        whole_nxt = TIME_W'(quo_r) * TIME_W'(duty_r);
        part_nxt  = FRAC_W'(rem) * FRAC_W'(duty_r);
        state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        frac_nxt  = frac_prod[FRAC_SH +: REM_W];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        on_len_nxt  = on_sum;
        off_len_nxt = period_r - on_sum;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      on_len_r  <= ON_LEN_RST;
      off_len_r <= OFF_LEN_RST;
    end else begin
      state_r   <= state_nxt;
      on_len_r  <= on_len_nxt;
      off_len_r <= off_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    duty_r   <= duty_nxt;
    quo_r    <= quo_nxt;
    whole_r  <= whole_nxt;
    part_r   <= part_nxt;
    frac_r   <= frac_nxt;
  end

  assign busy    = (state_r != ST_IDLE);
  assign on_len  = on_len_r;
  assign off_len = off_len_r;

endmodule
`default_nettype wire

FILE: hw/rtl/dcpt_phase.sv
`default_nettype none
module dcpt_phase
  import dcpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [1:0]        command,
  input  wire logic [TIME_W-1:0] now_ms,
  input  wire logic [TIME_W-1:0] period,
  input  wire logic [TIME_W-1:0] on_len,
  input  wire logic [TIME_W-1:0] off_len,
  output dcpt_result_t           result
);

  logic              enabled_r, enabled_nxt;
  logic              on_phase_r, on_phase_nxt;
  logic [TIME_W-1:0] phase_start_r, phase_start_nxt;
  logic [TIME_W-1:0] last_tick_r, last_tick_nxt;
  logic [TIME_W-1:0] phase_elapsed;
  logic [TIME_W-1:0] tick_elapsed;
  logic [TIME_W-1:0] limit;
  logic              fired;

  assign phase_elapsed = now_ms - phase_start_r;
  assign tick_elapsed  = now_ms - last_tick_r;
  assign limit         = on_phase_r ? on_len : off_len;

  always_comb begin
    enabled_nxt     = enabled_r;
    on_phase_nxt    = on_phase_r;
    phase_start_nxt = phase_start_r;
    last_tick_nxt   = last_tick_r;
    fired           = 1'b0;
    case (dcpt_cmd_t'(command))
      CMD_UPDATE: begin
        if (enabled_r && (phase_elapsed >= limit)) begin
          on_phase_nxt    = ~on_phase_r;
          phase_start_nxt = now_ms;
        end
      end
      CMD_TICK: begin
        if (enabled_r && (tick_elapsed >= period)) begin
          last_tick_nxt = now_ms;
          fired         = 1'b1;
        end
      end
      CMD_START: begin
        enabled_nxt     = 1'b1;
        on_phase_nxt    = 1'b1;
        last_tick_nxt   = now_ms;
        phase_start_nxt = now_ms;
      end
      default: begin
        enabled_nxt     = 1'b0;
        on_phase_nxt    = 1'b0;
        phase_start_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      on_phase_r    <= 1'b0;
      phase_start_r <= '0;
      last_tick_r   <= '0;
    end else if (accept) begin
      enabled_r     <= enabled_nxt;
      on_phase_r    <= on_phase_nxt;
      phase_start_r <= phase_start_nxt;
      last_tick_r   <= last_tick_nxt;
    end
  end

  assign result.running    = enabled_nxt;
  assign result.phase_on   = on_phase_nxt;
  assign result.tick_fired = fired;

endmodule
`default_nettype wire

FILE: hw/rtl/dcpt_out_buf.sv
`default_nettype none
module dcpt_out_buf
  import dcpt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire dcpt_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  wire logic   out_stall,
  output dcpt_result_t out_data
);

  logic         main_vld_r, main_vld_nxt;
  logic         skid_vld_r, skid_vld_nxt;
  dcpt_result_t main_r, main_nxt;
  dcpt_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop = main_vld_r && !out_stall;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule
`default_nettype wire

FILE: hw/rtl/duty_cycle_phase_timer_core.sv
// Duty-cycle phase timer.
// Input channel (in_valid/in_stall): one command with a timestamp per item:
//   update phase, tick check, start or stop. Every item yields exactly one
//   result item on the output channel (out_valid/out_stall) carrying
//   running, phase_on and tick_fired after that command.
// Results are registered in the output buffer; one item per cycle is
//   sustained while in_stall is low, since each command is a subtract and
//   compare against registered times plus the precomputed on/off lengths.
// Config port (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 period,
//   index 1 duty percent; other indexes are ignored. A write recomputes the
//   on/off lengths by a reciprocal multiply by 1/100 in steps: multiply,
//   part, fraction, sum; meanwhile cfg_ready is low and in_stall is high.
// When the receiver stalls, the result holds in an output register and one
//   further item is taken into a skid register; then in_stall rises.
// Reset (rst_n low, synchronous): timer stopped, off phase, times zero,
//   period 1000, duty 50, on/off lengths 500/500, output empty.
`default_nettype none
module duty_cycle_phase_timer_core
  import dcpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_command,
  input  wire logic [TIME_W-1:0]    in_now_ms,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_running,
  output logic                      out_phase_on,
  output logic                      out_tick_fired,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  logic [TIME_W-1:0] period_r, period_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              cfg_wr;
  logic              len_start;
  logic              len_busy;
  logic [TIME_W-1:0] on_len;
  logic [TIME_W-1:0] off_len;
  logic              buf_full;
  logic              in_accept;
  dcpt_result_t      step_res;
  dcpt_result_t      out_res;

  assign cfg_ready = !len_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    period_nxt = period_r;
    duty_nxt   = duty_r;
    len_start  = 1'b0;
    if (cfg_wr) begin
      case (dcpt_reg_t'(cfg_index))
        REG_PERIOD: begin
          period_nxt = (cfg_data == '0) ? TIME_W'(1) : cfg_data;
          len_start  = 1'b1;
        end
        REG_DUTY: begin
          duty_nxt  = cfg_data[DUTY_W-1:0];
          len_start = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      duty_r   <= DUTY_RST;
    end else begin
      period_r <= period_nxt;
      duty_r   <= duty_nxt;
    end
  end

  dcpt_len_unit u_len (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (len_start),
    .period  (period_nxt),
    .duty    (clamp_duty(duty_nxt)),
    .busy    (len_busy),
    .on_len  (on_len),
    .off_len (off_len)
  );

  assign in_stall  = len_busy || buf_full;
  assign in_accept = in_valid && !in_stall;

  dcpt_phase u_phase (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .command (in_command),
    .now_ms  (in_now_ms),
    .period  (period_r),
    .on_len  (on_len),
    .off_len (off_len),
    .result  (step_res)
  );

  dcpt_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_running    = out_res.running;
  assign out_phase_on   = out_res.phase_on;
  assign out_tick_fired = out_res.tick_fired;

endmodule
`default_nettype wire

FILE: dv/duty_cycle_phase_timer_checker.sv
module duty_cycle_phase_timer_checker
  import dcpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [1:0]           in_command,
  input  wire logic [TIME_W-1:0]    in_now_ms,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic                 out_running,
  input  wire logic                 out_phase_on,
  input  wire logic                 out_tick_fired,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic              timer_on;
  logic              phase_high;
  logic [TIME_W-1:0] phase_mark;
  logic [TIME_W-1:0] tick_mark;
  logic [TIME_W-1:0] period_q;
  logic [DUTY_W-1:0] duty_q;
  logic [TIME_W-1:0] on_len;
  logic [TIME_W-1:0] off_len;

  dcpt_result_t status_q[$];
  int           mismatches  = 0;
  int           outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic void refresh_lengths();
    logic [DUTY_W-1:0] pct;
    logic [63:0]       prod;
    pct = duty_q;
    if (pct < DUTY_MIN) pct = DUTY_MIN;
    if (pct > DUTY_MAX) pct = DUTY_MAX;
    prod    = 64'(period_q) * 64'(pct);
    on_len  = TIME_W'(prod / 64'(PCT_DIVISOR));
    off_len = period_q - on_len;
  endfunction

  function automatic dcpt_result_t advance_timer(input dcpt_cmd_t cmd,
                                                 input logic [TIME_W-1:0] now);
    dcpt_result_t      res;
    logic [TIME_W-1:0] span_lim;
    res = '0;
    case (cmd)
      CMD_UPDATE: begin
        if (timer_on) begin
          span_lim = phase_high ? on_len : off_len;
          if (now - phase_mark >= span_lim) begin
            phase_high = !phase_high;
            phase_mark = now;
          end
        end
      end
      CMD_TICK: begin
        if (timer_on && (now - tick_mark >= period_q)) begin
          tick_mark      = now;
          res.tick_fired = 1'b1;
        end
      end
      CMD_START: begin
        timer_on   = 1'b1;
        phase_high = 1'b1;
        tick_mark  = now;
        phase_mark = now;
      end
      default: begin
        timer_on   = 1'b0;
        phase_high = 1'b0;
        phase_mark = '0;
      end
    endcase
    res.running  = timer_on;
    res.phase_on = phase_high;
    return res;
  endfunction

  always @(posedge clk) begin
    dcpt_result_t want;
    if (!rst_n) begin
      timer_on   = 1'b0;
      phase_high = 1'b0;
      phase_mark = '0;
      tick_mark  = '0;
      period_q   = PERIOD_RST;
      duty_q     = DUTY_RST;
      refresh_lengths();
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $error("result item with nothing expected: running %0b phase_on %0b tick_fired %0b",
                 out_running, out_phase_on, out_tick_fired);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          if (out_running !== want.running) begin
            $error("running: expected %0b, actual %0b", want.running, out_running);
            mismatches++;
          end
          if (out_phase_on !== want.phase_on) begin
            $error("phase_on: expected %0b, actual %0b", want.phase_on, out_phase_on);
            mismatches++;
          end
          if (out_tick_fired !== want.tick_fired) begin
            $error("tick_fired: expected %0b, actual %0b", want.tick_fired, out_tick_fired);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PERIOD) begin
          period_q = (cfg_data == '0) ? TIME_W'(1) : cfg_data;
          refresh_lengths();
        end else if (cfg_index == REG_DUTY) begin
          duty_q = cfg_data[DUTY_W-1:0];
          refresh_lengths();
        end
      end
      if (in_valid && !in_stall)
        status_q.push_back(advance_timer(dcpt_cmd_t'(in_command), in_now_ms));
    end
    outstanding = status_q.size();
  end

endmodule

FILE: dv/tb_duty_cycle_phase_timer_core.sv
module tb_duty_cycle_phase_timer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dcpt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 113;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic [1:0]           in_command = CMD_UPDATE;
  logic [TIME_W-1:0]    in_now_ms  = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_PERIOD;
  logic [TIME_W-1:0]    cfg_data   = '0;

  wire logic in_stall;
  wire logic out_valid;
  wire logic out_running;
  wire logic out_phase_on;
  wire logic out_tick_fired;
  wire logic cfg_ready;

  int fail_count;
  int pending;

  int                idle_pct     = 0;
  bit                hold_request = 1'b0;
  int                cycle_count  = 0;
  logic [TIME_W-1:0] cur_period   = PERIOD_RST;

  duty_cycle_phase_timer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_running    (out_running),
    .out_phase_on   (out_phase_on),
    .out_tick_fired (out_tick_fired),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  duty_cycle_phase_timer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_running    (out_running),
    .out_phase_on   (out_phase_on),
    .out_tick_fired (out_tick_fired),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (rst_n && $urandom_range(0, 99) < idle_pct) begin
        burst = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input dcpt_cmd_t cmd, input logic [TIME_W-1:0] stamp);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_now_ms  <= stamp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx == REG_PERIOD)
      cur_period = (data == '0) ? TIME_W'(1) : data;
  endtask

  task automatic configure(input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] duty);
    drain();
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
    write_reg(REG_PERIOD, period);
    write_reg(REG_DUTY, duty);
    cfg_valid <= 1'b0;
  endtask

  function automatic dcpt_cmd_t pick_command(input bit active);
    int r;
    r = $urandom_range(0, 99);
    if (!active)
      return (r < 80) ? CMD_START : ((r < 88) ? CMD_UPDATE : ((r < 95) ? CMD_TICK : CMD_STOP));
    if (r < 48) return CMD_UPDATE;
    if (r < 88) return CMD_TICK;
    if (r < 94) return CMD_START;
    return CMD_STOP;
  endfunction

  // mostly forward steps on the scale of the period; some jumps and rewinds
  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] t);
    int unsigned span;
    int          r;
    span = (cur_period > 32'd3000) ? 3000 : int'(cur_period);
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return t - $urandom_range(1, 64);
    return t + $urandom_range(0, span);
  endfunction

  initial begin
    logic [TIME_W-1:0] stamp;
    dcpt_cmd_t         cmd;
    bit                active;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stopped timer ignores update and tick
    send(CMD_UPDATE, 32'h0000_0000);
    send(CMD_TICK, 32'hFFFF_FFFF);
    send(CMD_STOP, 32'h5555_AAAA);
    // reset lengths 500/500, period 1000
    send(CMD_START, 32'd100);
    send(CMD_UPDATE, 32'd599);
    send(CMD_UPDATE, 32'd600);
    send(CMD_UPDATE, 32'd1099);
    send(CMD_UPDATE, 32'd1100);
    send(CMD_TICK, 32'd1099);
    send(CMD_TICK, 32'd1100);
    send(CMD_TICK, 32'd1100);
    // restart while running, then timestamps across the wrap and backwards
    send(CMD_START, 32'hFFFF_FF00);
    send(CMD_UPDATE, 32'h0000_00F4);
    send(CMD_TICK, 32'h0000_02E8);
    send(CMD_UPDATE, 32'h0000_0010);
    send(CMD_TICK, 32'h0000_0000);
    send(CMD_STOP, 32'd1234);
    send(CMD_TICK, 32'd5000);
    send(CMD_START, 32'hAAAA_5555);
    // zero-length on phase
    configure(32'd1, 32'd0);
    send(CMD_START, 32'd5);
    send(CMD_UPDATE, 32'd5);
    send(CMD_UPDATE, 32'd5);
    send(CMD_UPDATE, 32'd6);
    send(CMD_TICK, 32'd6);
    active = 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(32'd1, 32'd0);
        1: configure(32'd0, 32'd255);
        2: configure(32'd7, 32'd50);
        3: configure(32'd100, 32'd10);
        4: configure(32'hFFFF_FFFF, 32'd90);
        5: configure($urandom(), $urandom_range(0, 255));
        default: configure($urandom_range(2, 500), $urandom_range(0, 255));
      endcase
      idle_pct = (p == 0 || p >= PHASES - 2) ? 0 : $urandom_range(10, 50);
      if (p == 3) hold_request = 1'b1;
      stamp = (p % 2 == 0) ? $urandom() : 32'hFFFF_FFFF - $urandom_range(0, 2000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        cmd   = pick_command(active);
        stamp = next_stamp(stamp);
        send(cmd, stamp);
        if (cmd == CMD_START) active = 1'b1;
        if (cmd == CMD_STOP) active = 1'b0;
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
